@@ hw/rtl/chtu_pkg.sv @@
package chtu_pkg;

    typedef enum logic [1:0] {
        FUNC_SET    = 2'd0,
        FUNC_GET    = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_hash_ctl;

endpackage

@@ hw/rtl/chained_hash_table_u64.sv @@
// Hash table with separate chaining on 64-bit keys. Each transaction (set, get,
// remove) hashes the key on one shared 32x32 multiplier, takes a bit-serial
// remainder by the bucket count through a handshake with the hash unit, then
// reads the bucket head and walks the chain nodes through the node memory before
// the update and output; o_stall is deasserted only when idle. After reset a
// clearing pass empties the bucket heads, during which no transaction is
// accepted. The bucket count register is written with 0 meaning 1 and values
// above BUCKETS clamped.
module chained_hash_table_u64
    import chtu_pkg::*;
#(
    parameter int BUCKETS = 512,
    parameter int NODES   = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [63:0] i_key,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_found,
    output logic [31:0] o_value_out,
    output logic        o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [9:0]  i_cfg_bucket_count
);
    localparam int BB = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NI = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int NB = $clog2(NODES + 1);
    localparam int DW = $clog2(BUCKETS + 1);
    localparam logic [NB-1:0] NIL = NB'(NODES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_HEAD, S_HEADW, S_READ, S_READW, S_CHECK,
        S_ALLOC, S_ALLOCW, S_FREE, S_OUT
    } t_state;

    t_state          r_state;
    logic [DW-1:0]   r_div;
    logic [BB-1:0]   r_clr;
    logic [1:0]      r_func;
    logic [63:0]     r_key;
    logic [31:0]     r_val;
    logic [BB-1:0]   r_b;
    logic [NB-1:0]   r_n;
    logic [NB-1:0]   r_prev;
    logic [NB-1:0]   r_steps;
    logic [NB-1:0]   r_free;
    logic [NB-1:0]   r_fresh;
    logic            r_found;
    logic [31:0]     r_vout;
    logic            r_status;
    logic            r_ovalid;
    logic            r_res_found;
    logic [31:0]     r_res_vout;
    logic            r_res_status;

    logic [NB-1:0]   r_head_mem [BUCKETS];
    logic [63:0]     r_key_mem [NODES];
    logic [31:0]     r_val_mem [NODES];
    logic [NB-1:0]   r_next_mem [NODES];
    logic [NB-1:0]   r_head_q;
    logic [63:0]     r_key_q;
    logic [31:0]     r_val_q;
    logic [NB-1:0]   r_next_q;

    logic            w_hstart;
    t_hash_ctl       w_hctl;
    logic [DW-1:0]   w_bucket;
    logic [DW-1:0]   w_cfg_div;
    logic            w_take;
    logic [NB-1:0]   w_nidx;

    chtu_hash #(.BW(DW)) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_hstart),
        .i_key    (r_key),
        .i_div    (r_div),
        .o_ctl    (w_hctl),
        .o_bucket (w_bucket)
    );

    always_comb begin
        if (i_cfg_bucket_count == 10'd0) w_cfg_div = DW'(1);
        else if ({22'd0, i_cfg_bucket_count} > BUCKETS) w_cfg_div = DW'(BUCKETS);
        else w_cfg_div = DW'(i_cfg_bucket_count);
    end

    assign w_hstart    = (r_state == S_HASH) && !w_hctl.busy;
    assign w_take      = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_found     = r_res_found;
    assign o_value_out = r_res_vout;
    assign o_status    = r_res_status;
    assign w_nidx      = (r_free != NIL) ? r_free : r_fresh;

    always_ff @(posedge i_clk) begin
        r_head_q <= r_head_mem[r_b];
        r_key_q  <= r_key_mem[r_n[NI-1:0]];
        r_val_q  <= r_val_mem[r_n[NI-1:0]];
        r_next_q <= r_next_mem[r_n[NI-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_div    <= DW'(BUCKETS);
            r_free   <= NIL;
            r_fresh  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_div <= w_cfg_div;
            if (r_state == S_OUT && (!r_ovalid || !i_stall)) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_head_mem[r_clr] <= NIL;
                    r_clr <= r_clr + BB'(1);
                    if (r_clr == BB'(BUCKETS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (w_take) begin
                        r_func   <= i_func;
                        r_key    <= i_key;
                        r_val    <= i_value;
                        r_found  <= 1'b0;
                        r_vout   <= '0;
                        r_status <= 1'b0;
                        r_prev   <= NIL;
                        r_steps  <= '0;
                        r_state  <= (t_func'(i_func) == FUNC_NONE) ? S_OUT : S_HASH;
                    end
                end
                S_HASH: begin
                    if (w_hctl.done) begin
                        r_b     <= BB'(w_bucket);
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: r_state <= S_HEADW;
                S_HEADW: begin
                    r_n     <= r_head_q;
                    r_state <= S_READ;
                end
                S_READ: begin
                    if (r_n == NIL || r_steps == NIL) begin
                        r_n     <= r_free;
                        r_state <= (t_func'(r_func) == FUNC_SET) ? S_ALLOCW : S_OUT;
                    end else begin
                        r_state <= S_READW;
                    end
                end
                S_READW: r_state <= S_CHECK;
                S_CHECK: begin
                    if (r_key_q == r_key) begin
                        r_found <= 1'b1;
                        r_state <= (t_func'(r_func) == FUNC_REMOVE) ? S_FREE : S_OUT;
                        unique case (t_func'(r_func))
                            FUNC_SET: r_val_mem[r_n[NI-1:0]] <= r_val;
                            FUNC_GET: r_vout <= r_val_q;
                            FUNC_REMOVE: begin
                                if (r_prev != NIL) r_next_mem[r_prev[NI-1:0]] <= r_next_q;
                                else r_head_mem[r_b] <= r_next_q;
                            end
                            default: ;
                        endcase
                    end else begin
                        r_prev  <= r_n;
                        r_n     <= r_next_q;
                        r_steps <= r_steps + NB'(1);
                        r_state <= S_READ;
                    end
                end
                S_FREE: begin
                    r_next_mem[r_n[NI-1:0]] <= r_free;
                    r_free  <= r_n;
                    r_state <= S_OUT;
                end
                S_ALLOCW: r_state <= S_ALLOC;
                S_ALLOC: begin
                    if (w_nidx == NIL) begin
                        r_status <= 1'b1;
                    end else begin
                        r_key_mem[w_nidx[NI-1:0]]  <= r_key;
                        r_val_mem[w_nidx[NI-1:0]]  <= r_val;
                        r_next_mem[w_nidx[NI-1:0]] <= r_head_q;
                        r_head_mem[r_b]            <= w_nidx;
                        if (r_free != NIL) r_free <= r_next_q;
                        else r_fresh <= r_fresh + NB'(1);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_res_found  <= r_found;
                        r_res_vout   <= r_vout;
                        r_res_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> r_state == S_IDLE) else $error("result without return to idle");
    a_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= NIL) else $error("fresh count overflow");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_found) && $stable(o_value_out))
        else $error("stalled result changed");
`endif
endmodule

@@ hw/rtl/chtu_hash.sv @@
module chtu_hash
    import chtu_pkg::*;
#(
    parameter int BW = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_key,
    input  logic [BW-1:0] i_div,
    output t_hash_ctl     o_ctl,
    output logic [BW-1:0] o_bucket
);
    // Splitmix64 finalizer through one shared 32x32 multiplier, then a restoring
    // remainder by the bucket count, one bit a cycle.
    typedef enum logic [2:0] {S_IDLE, S_MUL1, S_MUL2, S_MOD, S_DONE} t_state;

    t_state        r_state;
    logic [63:0]   r_x;
    logic [63:0]   r_acc;
    logic [1:0]    r_part;
    logic [5:0]    r_bit;
    logic [BW:0]   r_rem;
    logic [63:0]   w_c;
    logic [31:0]   w_a;
    logic [31:0]   w_b;
    logic [63:0]   w_p;
    logic [63:0]   w_sum;
    logic [BW:0]   w_sh;
    logic [63:0]   w_h2;

    assign w_c = (r_state == S_MUL1) ? MIX_C1 : MIX_C2;
    assign w_a = r_part[1] ? r_x[63:32] : r_x[31:0];
    assign w_b = r_part[0] ? w_c[63:32] : w_c[31:0];
    assign w_p = w_a * w_b;
    always_comb begin
        unique case (r_part)
            2'd0: w_sum = r_acc + w_p;
            2'd1, 2'd2: w_sum = r_acc + {w_p[31:0], 32'd0};
            default: w_sum = r_acc;
        endcase
    end
    assign w_h2 = w_sum ^ (w_sum >> 27);
    assign w_sh = {r_rem[BW-1:0], r_x[r_bit]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_key ^ (i_key >> 30);
                        r_acc   <= '0;
                        r_part  <= '0;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1, S_MUL2: begin
                    r_acc  <= (r_part == 2'd3) ? '0 : w_sum;
                    r_part <= r_part + 2'd1;
                    if (r_part == 2'd3) begin
                        if (r_state == S_MUL1) begin
                            r_x     <= w_h2;
                            r_state <= S_MUL2;
                        end else begin
                            r_x     <= w_sum ^ (w_sum >> 31);
                            r_bit   <= 6'd63;
                            r_rem   <= '0;
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    if (w_sh >= {1'b0, i_div}) r_rem <= w_sh - {1'b0, i_div};
                    else r_rem <= w_sh;
                    r_bit <= r_bit - 6'd1;
                    if (r_bit == 6'd0) r_state <= S_DONE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = (r_state != S_IDLE);
    assign o_ctl.done  = (r_state == S_DONE);
    assign o_bucket    = r_rem[BW-1:0];
endmodule

@@ tb/tb_chained_hash_table_u64.sv @@
module tb_chained_hash_table_u64;
    import chtu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_BUCKETS = 512;
    localparam int N_NODES = 1024;
    localparam int NIL = N_NODES;
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct {
        logic        found;
        logic [31:0] value_out;
        logic        status;
    } t_outcome;

    typedef struct {
        t_func       func;
        logic [63:0] key;
        logic [31:0] value;
        bit          typed;
        t_outcome    outcome;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_func;
    logic [63:0] i_key;
    logic [31:0] i_value;
    logic        o_valid;
    logic        i_stall;
    logic        o_found;
    logic [31:0] o_value_out;
    logic        o_status;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [9:0]  i_cfg_bucket_count;

    chained_hash_table_u64 i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_func             (i_func),
        .i_key              (i_key),
        .i_value            (i_value),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_found            (o_found),
        .o_value_out        (o_value_out),
        .o_status           (o_status),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_bucket_count (i_cfg_bucket_count)
    );

    // Shadow copy of the table contents.
    logic [9:0]  tbl_count;
    int          tbl_head [N_BUCKETS];
    logic [63:0] tbl_key [N_NODES];
    logic [31:0] tbl_val [N_NODES];
    int          tbl_next [N_NODES];
    int          tbl_free;
    int          tbl_fresh;

    t_outcome    pending_results [$];
    int          errors = 0;
    int          quiet_cycles = 0;
    int          snd_idle_pct = 0;
    int          rcv_stall_pct = 0;

    function automatic logic [63:0] splitmix(logic [63:0] x);
        x = (x ^ (x >> 30)) * MIX_C1;
        x = (x ^ (x >> 27)) * MIX_C2;
        return x ^ (x >> 31);
    endfunction

    function automatic t_outcome table_apply(t_func f, logic [63:0] k, logic [31:0] v);
        t_outcome   res;
        logic [63:0] n_eff;
        int         b;
        int         prv;
        int         n;
        int         steps;
        res = '{1'b0, 32'd0, 1'b0};
        if (f == FUNC_NONE) return res;
        n_eff = (tbl_count == 0) ? 1 : ((tbl_count > N_BUCKETS) ? N_BUCKETS : tbl_count);
        b = int'(splitmix(k) % n_eff);
        prv = NIL;
        n = tbl_head[b];
        steps = 0;
        while (n < NIL && steps < N_NODES && tbl_key[n] != k) begin
            prv = n;
            n = tbl_next[n];
            steps++;
        end
        if (steps >= N_NODES) n = NIL;
        case (f)
            FUNC_SET: begin
                if (n < NIL) begin
                    res.found = 1'b1;
                    tbl_val[n] = v;
                end else begin
                    if (tbl_free < NIL) begin
                        n = tbl_free;
                        tbl_free = tbl_next[n];
                    end else if (tbl_fresh < N_NODES) begin
                        n = tbl_fresh;
                        tbl_fresh++;
                    end
                    if (n < NIL) begin
                        tbl_key[n] = k;
                        tbl_val[n] = v;
                        tbl_next[n] = tbl_head[b];
                        tbl_head[b] = n;
                    end else begin
                        res.status = 1'b1;
                    end
                end
            end
            FUNC_GET: begin
                if (n < NIL) begin
                    res.found = 1'b1;
                    res.value_out = tbl_val[n];
                end
            end
            default: begin
                if (n < NIL) begin
                    res.found = 1'b1;
                    if (prv < NIL) tbl_next[prv] = tbl_next[n];
                    else tbl_head[b] = tbl_next[n];
                    tbl_next[n] = tbl_free;
                    tbl_free = n;
                end
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic send_op(t_func f, logic [63:0] k, logic [31:0] v, bit typed = 0,
                           t_outcome typed_res = '{1'b0, 32'd0, 1'b0});
        t_outcome res;
        if ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < snd_idle_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= f;
        i_key <= k;
        i_value <= v;
        do @(posedge i_clk); while (o_stall);
        res = table_apply(f, k, v);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_bucket_count(logic [9:0] cnt);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_bucket_count <= cnt;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tbl_count = cnt;
    endtask

    task automatic run_random_phase(int n_items, int snd_pct, int rcv_pct);
        logic [63:0] keys [12];
        int          sel;
        t_func       f;
        snd_idle_pct = snd_pct;
        rcv_stall_pct = rcv_pct;
        foreach (keys[i]) keys[i] = {$urandom, $urandom};
        keys[0] = 64'd0;
        keys[1] = '1;
        for (int i = 0; i < n_items; i++) begin
            sel = $urandom_range(99);
            f = (sel < 40) ? FUNC_SET : (sel < 70) ? FUNC_GET : (sel < 95) ? FUNC_REMOVE
                : FUNC_NONE;
            send_op(f, keys[$urandom_range(11)], $urandom);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_outcome want;
        i_stall <= ($urandom_range(99) < rcv_stall_pct);
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction", 0, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_found !== want.found) report_mismatch("found", o_found, want.found);
                if (o_value_out !== want.value_out)
                    report_mismatch("value_out", o_value_out, want.value_out);
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
            end
        end
    end

    initial begin
        t_row        rows [$];
        logic [63:0] filled [$];
        int          extra;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = FUNC_NONE;
        i_key = '0;
        i_value = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_bucket_count = '0;
        tbl_count = 10'd512;
        foreach (tbl_head[i]) tbl_head[i] = NIL;
        foreach (tbl_next[i]) tbl_next[i] = NIL;
        tbl_free = NIL;
        tbl_fresh = 0;

        rows = '{
            '{FUNC_GET,    64'd0,  32'd0,        1, '{1'b0, 32'd0, 1'b0}},
            '{FUNC_REMOVE, '1,     32'hFFFFFFFF, 1, '{1'b0, 32'd0, 1'b0}},
            '{FUNC_SET,    64'd0,  32'hFFFFFFFF, 1, '{1'b0, 32'd0, 1'b0}},
            '{FUNC_GET,    64'd0,  32'd0,        1, '{1'b1, 32'hFFFFFFFF, 1'b0}},
            '{FUNC_SET,    '1,     32'd0,        1, '{1'b0, 32'd0, 1'b0}},
            '{FUNC_GET,    '1,     32'hFFFFFFFF, 1, '{1'b1, 32'd0, 1'b0}},
            '{FUNC_SET,    64'd0,  32'h12345678, 1, '{1'b1, 32'd0, 1'b0}},
            '{FUNC_GET,    64'd0,  32'd0,        1, '{1'b1, 32'h12345678, 1'b0}},
            '{FUNC_NONE,   64'd0,  32'hFFFFFFFF, 1, '{1'b0, 32'd0, 1'b0}},
            '{FUNC_REMOVE, 64'd0,  32'd0,        1, '{1'b1, 32'd0, 1'b0}},
            '{FUNC_GET,    64'd0,  32'd0,        1, '{1'b0, 32'd0, 1'b0}},
            '{FUNC_REMOVE, 64'd0,  32'd0,        1, '{1'b0, 32'd0, 1'b0}},
            '{FUNC_SET,    64'h8000000000000000, 32'hAAAAAAAA, 0, '{1'b0, 32'd0, 1'b0}},
            '{FUNC_SET,    64'd1,  32'h55555555, 0, '{1'b0, 32'd0, 1'b0}},
            '{FUNC_GET,    64'd1,  32'd0,        0, '{1'b0, 32'd0, 1'b0}},
            '{FUNC_GET,    64'h8000000000000000, 32'd0, 0, '{1'b0, 32'd0, 1'b0}},
            '{FUNC_NONE,   '1,     32'h0000FFFF, 1, '{1'b0, 32'd0, 1'b0}},
            '{FUNC_GET,    '1,     32'd0,        1, '{1'b1, 32'd0, 1'b0}},
            '{FUNC_REMOVE, '1,     32'd0,        1, '{1'b1, 32'd0, 1'b0}},
            '{FUNC_REMOVE, 64'd1,  32'd0,        0, '{1'b0, 32'd0, 1'b0}}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) send_op(rows[i].func, rows[i].key, rows[i].value,
                                  rows[i].typed, rows[i].outcome);

        write_bucket_count(10'd1);
        run_random_phase(60, 0, 0);
        write_bucket_count(10'd0);
        run_random_phase(60, 68, 0);
        write_bucket_count(10'd1023);
        run_random_phase(60, 0, 68);
        write_bucket_count(10'd37);
        run_random_phase(60, 20, 20);

        // Exhaust the node pool, then free and reuse some nodes.
        write_bucket_count(10'd512);
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        extra = 0;
        while (extra < 8) begin
            filled.push_back({$urandom, $urandom});
            send_op(FUNC_SET, filled[$], $urandom);
            if (tbl_fresh == N_NODES && tbl_free == NIL) extra++;
        end
        snd_idle_pct = 20;
        rcv_stall_pct = 20;
        for (int i = 0; i < 40; i++) begin
            send_op(($urandom_range(1) != 0) ? FUNC_REMOVE : FUNC_GET,
                    filled[$urandom_range(filled.size() - 1)], $urandom);
        end
        for (int i = 0; i < 30; i++) send_op(FUNC_SET, {$urandom, $urandom}, $urandom);

        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
